### src/lcbx_pkg.sv
// ----------------------------------------------------------------------------
// lcbx_pkg: shared types for the link cable bit exchange core
// Event and message codes, protocol phases, and the item, result and state
// records passed between the core and its step logic.
// ----------------------------------------------------------------------------
package lcbx_pkg;

  // field widths
  localparam int unsigned ModeW   = 4;
  localparam int unsigned KindW   = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 4;
  localparam int unsigned SDataW  = 16;
  localparam int unsigned MDataW  = 16;
  localparam int unsigned MaxBits = 8;

  // value the shift register takes when a clock collision aborts a transfer
  localparam logic [ByteW-1:0] AbortValue = 8'hFF;

  // local events and peer messages
  typedef enum logic [ModeW-1:0] {
    MODE_LOCAL_CLOCK = 4'd0,
    MODE_START_EXT   = 4'd1,
    MODE_PEER_CLOCK  = 4'd2,
    MODE_PEER_ACK    = 4'd3,
    MODE_PEER_NAK    = 4'd4,
    MODE_PEER_DATA   = 4'd5,
    MODE_PEER_CLOSE  = 4'd6,
    MODE_LOAD        = 4'd7,
    MODE_UNPLUG      = 4'd8,
    MODE_PLUG        = 4'd9
  } lcbx_mode_e;

  // messages sent to the peer
  typedef enum logic [KindW-1:0] {
    KIND_NONE  = 3'd0,
    KIND_CLOCK = 3'd1,
    KIND_ACK   = 3'd2,
    KIND_NAK   = 3'd3,
    KIND_DATA  = 3'd4,
    KIND_CLOSE = 3'd5
  } lcbx_kind_e;

  // protocol phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_EXT_CLOCK = 5'b00010,
    PH_EXT_DATA  = 5'b00100,
    PH_CLOCK     = 5'b01000,
    PH_CLOCK_ACK = 5'b10000
  } lcbx_phase_e;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic              peer_bit;
    logic [ByteW-1:0]  load_byte;
    logic [CountW-1:0] load_count;
    logic              master_role;
  } lcbx_item_t;

  typedef struct packed {
    lcbx_kind_e       send_kind;
    logic             send_bit;
    logic [ByteW-1:0] shift_value;
    logic             serial_irq;
    logic             restart_timer;
    logic             last;
  } lcbx_result_t;

  typedef struct packed {
    lcbx_phase_e       phase;
    logic [ByteW-1:0]  shift_register;
    logic [CountW-1:0] bits_left;
    logic              prior_bit;
    logic              linked;
    logic              is_master;
  } lcbx_state_t;

endpackage

### src/lcbx_step.sv
// ----------------------------------------------------------------------------
// lcbx_step: next-state and message logic for one link event
// Takes the current protocol state and one event, and gives the next state
// and one or two result beats.
// ----------------------------------------------------------------------------
module lcbx_step (
  input  lcbx_pkg::lcbx_state_t  state_i,
  input  lcbx_pkg::lcbx_item_t   item_i,
  output lcbx_pkg::lcbx_state_t  state_o,
  output lcbx_pkg::lcbx_result_t res0_o,
  output lcbx_pkg::lcbx_result_t res1_o,
  output logic                   two_o
);
  import lcbx_pkg::*;

  logic [ByteW-1:0]  shifted;
  logic [CountW-1:0] bits_dec;
  logic              more_bits;
  logic              shift_in;
  lcbx_kind_e        kind;
  logic              sbit;
  logic              irq;
  logic              rt;
  logic              peer_msg;

  // bit intake: the shifted-in bit is the peer bit, or the previous one on NAK
  assign shift_in  = (item_i.mode == MODE_PEER_NAK) ? state_i.prior_bit : item_i.peer_bit;
  assign shifted   = {shift_in, state_i.shift_register[ByteW-1:1]};
  assign bits_dec  = (state_i.bits_left != '0) ? state_i.bits_left - CountW'(1) : '0;
  assign more_bits = (bits_dec != '0);

  // peer messages are dropped without a cable
  assign peer_msg = (item_i.mode >= MODE_PEER_CLOCK) && (item_i.mode <= MODE_PEER_CLOSE);

  // event decode
  always_comb begin
    state_o = state_i;
    kind    = KIND_NONE;
    sbit    = 1'b0;
    irq     = 1'b0;
    rt      = 1'b0;
    two_o   = 1'b0;
    if (!(peer_msg && !state_i.linked)) begin
      case (item_i.mode)
        MODE_LOCAL_CLOCK: begin
          if (state_i.linked && state_i.bits_left != '0 &&
              state_i.phase != PH_CLOCK && state_i.phase != PH_CLOCK_ACK) begin
            kind          = KIND_CLOCK;
            state_o.phase = PH_CLOCK;
          end
        end
        MODE_START_EXT: begin
          if (state_i.bits_left != '0) state_o.phase = PH_EXT_CLOCK;
        end
        MODE_PEER_CLOCK: begin
          case (state_i.phase)
            PH_CLOCK: begin
              // collision as slave: acknowledge then send our bit
              if (!state_i.is_master) begin
                state_o.phase = PH_EXT_DATA;
                two_o         = 1'b1;
              end
            end
            PH_CLOCK_ACK: begin
              // collision after our data went out: abort
              state_o.phase          = PH_IDLE;
              state_o.bits_left      = '0;
              state_o.shift_register = AbortValue;
              kind                   = KIND_NAK;
              irq                    = 1'b1;
            end
            PH_EXT_CLOCK: begin
              kind          = KIND_ACK;
              state_o.phase = PH_EXT_DATA;
            end
            PH_IDLE: kind = KIND_NAK;
            default: ;
          endcase
        end
        MODE_PEER_ACK: begin
          if (state_i.phase == PH_CLOCK) begin
            state_o.phase = PH_CLOCK_ACK;
            kind          = KIND_DATA;
            sbit          = state_i.shift_register[0];
          end
        end
        MODE_PEER_NAK: begin
          if (state_i.phase == PH_CLOCK) begin
            state_o.phase          = PH_IDLE;
            state_o.shift_register = shifted;
            state_o.bits_left      = bits_dec;
            rt                     = more_bits;
            irq                    = !more_bits;
          end
        end
        MODE_PEER_DATA: begin
          if (state_i.phase == PH_CLOCK_ACK) begin
            state_o.prior_bit      = item_i.peer_bit;
            state_o.phase          = PH_IDLE;
            state_o.shift_register = shifted;
            state_o.bits_left      = bits_dec;
            rt                     = more_bits;
            irq                    = !more_bits;
          end else if (state_i.phase == PH_EXT_DATA) begin
            kind                   = KIND_DATA;
            sbit                   = state_i.shift_register[0];
            state_o.prior_bit      = item_i.peer_bit;
            state_o.shift_register = shifted;
            state_o.bits_left      = bits_dec;
            irq                    = !more_bits;
            state_o.phase          = more_bits ? PH_EXT_CLOCK : PH_IDLE;
          end
        end
        MODE_PEER_CLOSE: state_o.linked = 1'b0;
        MODE_LOAD: begin
          state_o.shift_register = item_i.load_byte;
          state_o.bits_left      = (item_i.load_count > CountW'(MaxBits)) ?
                                   CountW'(MaxBits) : item_i.load_count;
        end
        MODE_UNPLUG: begin
          if (state_i.linked) kind = KIND_CLOSE;
          state_o.linked    = 1'b0;
          state_o.prior_bit = 1'b1;
        end
        MODE_PLUG: begin
          if (!state_i.linked) begin
            state_o.linked    = 1'b1;
            state_o.is_master = item_i.master_role;
            if (!item_i.master_role) state_o.phase = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // result beats; a collision gives ACK then DATA
  always_comb begin
    res0_o.send_kind     = two_o ? KIND_ACK : kind;
    res0_o.send_bit      = sbit;
    res0_o.shift_value   = state_o.shift_register;
    res0_o.serial_irq    = irq;
    res0_o.restart_timer = rt;
    res0_o.last          = !two_o;

    res1_o.send_kind     = KIND_DATA;
    res1_o.send_bit      = state_i.shift_register[0];
    res1_o.shift_value   = state_i.shift_register;
    res1_o.serial_irq    = 1'b0;
    res1_o.restart_timer = 1'b0;
    res1_o.last          = 1'b1;
  end

endmodule

### src/link_cable_bit_exchange_fsm_core.sv
// ----------------------------------------------------------------------------
// link_cable_bit_exchange_fsm_core: serial link bit exchange handshake
// An input beat passes the input register, then the result register, on its
// way to the first result beat. Throughput: one event per cycle while the
// result buffer has room; a clock collision event yields two result beats,
// held in the two-entry result buffer. Reset (asynchronous, active low) puts the
// link in idle, unplugged, with an empty shift register and no bits pending.
// ----------------------------------------------------------------------------
module link_cable_bit_exchange_fsm_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: peer_bit[0], load_byte[8:1], load_count[12:9], master_role[13]
  input  logic [lcbx_pkg::SDataW-1:0]  s_axis_tdata,
  // tuser: mode[3:0]
  input  logic [lcbx_pkg::ModeW-1:0]   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: send_bit[0], shift_value[8:1], serial_irq[9], restart_timer[10]
  output logic [lcbx_pkg::MDataW-1:0]  m_axis_tdata,
  // tuser: send_kind[2:0]
  output logic [lcbx_pkg::KindW-1:0]   m_axis_tuser,
  output logic                         m_axis_tlast
);
  import lcbx_pkg::*;

  lcbx_item_t   item_q;
  logic         in_valid_q;
  lcbx_state_t  state_q, state_d;
  lcbx_result_t res0, res1;
  logic         two;
  lcbx_result_t head_q, tail_q;
  logic [1:0]   out_cnt_q, out_cnt_d;
  logic         fire;
  logic         pop;

  // step stage advances when the result buffer can take up to two beats
  assign pop  = m_axis_tvalid && m_axis_tready;
  assign fire = in_valid_q && ((out_cnt_q == 2'd0) || (out_cnt_q == 2'd1 && m_axis_tready));
  assign s_axis_tready = !in_valid_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.mode        <= s_axis_tuser;
      item_q.peer_bit    <= s_axis_tdata[0];
      item_q.load_byte   <= s_axis_tdata[8:1];
      item_q.load_count  <= s_axis_tdata[12:9];
      item_q.master_role <= s_axis_tdata[13];
    end
  end

  // protocol step
  lcbx_step u_step (
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .res0_o  (res0),
    .res1_o  (res1),
    .two_o   (two)
  );

  // protocol state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= PH_IDLE;
      state_q.shift_register <= '0;
      state_q.bits_left      <= '0;
      state_q.prior_bit      <= 1'b1;
      state_q.linked         <= 1'b0;
      state_q.is_master      <= 1'b0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // result buffer count
  always_comb begin
    out_cnt_d = out_cnt_q;
    if (pop) out_cnt_d = out_cnt_d - 2'd1;
    if (fire) out_cnt_d = out_cnt_d + (two ? 2'd2 : 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= 2'd0;
    end else begin
      out_cnt_q <= out_cnt_d;
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      head_q <= res0;
      tail_q <= res1;
    end else if (pop) begin
      head_q <= tail_q;
    end
  end

  // output beat
  assign m_axis_tvalid = (out_cnt_q != 2'd0);
  assign m_axis_tdata  = {5'd0, head_q.restart_timer, head_q.serial_irq,
                          head_q.shift_value, head_q.send_bit};
  assign m_axis_tuser  = head_q.send_kind;
  assign m_axis_tlast  = head_q.last;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q != 2'd3)
    else $error("result buffer overfilled");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q == 2'd2 |-> !head_q.last && tail_q.last)
    else $error("collision pair out of order");

  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bits_left <= CountW'(MaxBits))
    else $error("bit count above byte size");

endmodule
